/* hdl/cau_pkg.sv */
// ----------------------------------------------------------------------------
// cau_pkg
// shared codes and control types for the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4
    } cau_op_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        logic       valid;
        logic [2:0] op;
        logic       dz;
        logic       ovf_re;
        logic       ovf_im;
        logic       neg_re;
        logic       neg_im;
    } cau_ctrl_t;

endpackage

/* hdl/cau_in_if.sv */
// ----------------------------------------------------------------------------
// cau_in_if
// operand channel: op code and two complex operands
// ----------------------------------------------------------------------------
interface cau_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   op;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;

    modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

/* hdl/cau_out_if.sv */
// ----------------------------------------------------------------------------
// cau_out_if
// result channel: complex result and status
// ----------------------------------------------------------------------------
interface cau_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic [1:0]                   status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

/* hdl/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined add, subtract, multiply, divide and magnitude on complex operands
// ----------------------------------------------------------------------------
// Accepts one operand beat per cycle and returns one result beat per operand
// beat, in order. The pipeline has DATA_WIDTH + 3 register stages: one
// multiplier stage, one setup stage, a chain of DATA_WIDTH bit cells that
// produce the quotient and square root bits one bit per cell, and the output
// register. The pipeline stalls as a whole only while a finished result is
// not taken.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    cau_in_if.sink     operand,
    cau_out_if.source  result
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int RW = 3 * W + F + 2;

    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;
    localparam logic signed [SW-1:0] RND  = SW'((64'd1 << F) - 64'd1);

    logic advance;

    // multiplier stage
    logic                 v0_reg;
    logic [2:0]           op0_reg;
    logic signed [PW-1:0] arbr_reg, aibi_reg, arbi_reg, aibr_reg;
    logic signed [PW-1:0] brbr_reg, bibi_reg, arar_reg, aiai_reg;
    logic signed [W:0]    s_re_reg, s_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= operand.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op0_reg  <= operand.op;
            arbr_reg <= operand.a_re * operand.b_re;
            aibi_reg <= operand.a_im * operand.b_im;
            arbi_reg <= operand.a_re * operand.b_im;
            aibr_reg <= operand.a_im * operand.b_re;
            brbr_reg <= operand.b_re * operand.b_re;
            bibi_reg <= operand.b_im * operand.b_im;
            arar_reg <= operand.a_re * operand.a_re;
            aiai_reg <= operand.a_im * operand.a_im;
            if (operand.op == OP_SUB)
            begin
                s_re_reg <= {operand.a_re[W-1], operand.a_re} - {operand.b_re[W-1], operand.b_re};
                s_im_reg <= {operand.a_im[W-1], operand.a_im} - {operand.b_im[W-1], operand.b_im};
            end
            else
            begin
                s_re_reg <= {operand.a_re[W-1], operand.a_re} + {operand.b_re[W-1], operand.b_re};
                s_im_reg <= {operand.a_im[W-1], operand.a_im} + {operand.b_im[W-1], operand.b_im};
            end
        end
    end

    // setup stage
    function automatic logic signed [SW-1:0] sx(input logic signed [PW-1:0] p);
        return {{2{p[PW-1]}}, p};
    endfunction

    function automatic logic signed [SW-1:0] trunc_f(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = v[SW-1] ? v + RND : v;
        return t >>> F;
    endfunction

    function automatic logic [SW-1:0] abs_f(input logic signed [SW-1:0] v);
        return v[SW-1] ? -v : v;
    endfunction

    logic signed [SW-1:0] mul_re, mul_im, num_re, num_im, den_s, aux_re, aux_im;
    logic [RW-1:0]        den_w, dvd_re, dvd_im, dlim, sa_w, sb_w;
    cau_ctrl_t            ctrl_s;

    always_comb
    begin
        mul_re = sx(arbr_reg) - sx(aibi_reg);
        mul_im = sx(arbi_reg) + sx(aibr_reg);
        num_re = sx(arbr_reg) + sx(aibi_reg);
        num_im = sx(aibr_reg) - sx(arbi_reg);
        den_s  = sx(brbr_reg) + sx(bibi_reg);
        den_w  = {{(RW-SW){1'b0}}, den_s};
        dvd_re = {{(RW-SW){1'b0}}, abs_f(num_re)} << F;
        dvd_im = {{(RW-SW){1'b0}}, abs_f(num_im)} << F;
        dlim   = den_w << W;
        sa_w   = {{(RW-SW){1'b0}}, sx(arar_reg) + sx(aiai_reg)};
        sb_w   = {{(RW-SW){1'b0}}, sx(brbr_reg) + sx(bibi_reg)};
        if (op0_reg == OP_MUL)
        begin
            aux_re = trunc_f(mul_re);
            aux_im = trunc_f(mul_im);
        end
        else
        begin
            aux_re = {{(SW-W-1){s_re_reg[W]}}, s_re_reg};
            aux_im = {{(SW-W-1){s_im_reg[W]}}, s_im_reg};
        end
        ctrl_s.valid  = v0_reg;
        ctrl_s.op     = op0_reg;
        ctrl_s.dz     = (den_s == '0);
        ctrl_s.ovf_re = (dvd_re >= dlim);
        ctrl_s.ovf_im = (dvd_im >= dlim);
        ctrl_s.neg_re = num_re[SW-1];
        ctrl_s.neg_im = num_im[SW-1];
    end

    cau_ctrl_t            ctrl_c   [0:W];
    logic [RW-1:0]        den_c    [0:W];
    logic [RW-1:0]        rem_re_c [0:W];
    logic [RW-1:0]        rem_im_c [0:W];
    logic [W-1:0]         q_re_c   [0:W];
    logic [W-1:0]         q_im_c   [0:W];
    logic [RW-1:0]        sr_a_c   [0:W];
    logic [RW-1:0]        sr_b_c   [0:W];
    logic [W-1:0]         rt_a_c   [0:W];
    logic [W-1:0]         rt_b_c   [0:W];
    logic signed [SW-1:0] aux_re_c [0:W];
    logic signed [SW-1:0] aux_im_c [0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_c[0] <= '0;
        end
        else if (advance)
        begin
            ctrl_c[0] <= ctrl_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            den_c[0]    <= den_w;
            rem_re_c[0] <= dvd_re;
            rem_im_c[0] <= dvd_im;
            q_re_c[0]   <= '0;
            q_im_c[0]   <= '0;
            sr_a_c[0]   <= sa_w;
            sr_b_c[0]   <= sb_w;
            rt_a_c[0]   <= '0;
            rt_b_c[0]   <= '0;
            aux_re_c[0] <= aux_re;
            aux_im_c[0] <= aux_im;
        end
    end

    // bit cell chain
    for (genvar i = 0; i < W; i++)
    begin : g_cell
        cau_cell #(
            .W  (W),
            .RW (RW),
            .SW (SW),
            .K  (W - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .ctrl_i   (ctrl_c[i]),
            .den_i    (den_c[i]),
            .rem_re_i (rem_re_c[i]),
            .rem_im_i (rem_im_c[i]),
            .q_re_i   (q_re_c[i]),
            .q_im_i   (q_im_c[i]),
            .sr_a_i   (sr_a_c[i]),
            .sr_b_i   (sr_b_c[i]),
            .rt_a_i   (rt_a_c[i]),
            .rt_b_i   (rt_b_c[i]),
            .aux_re_i (aux_re_c[i]),
            .aux_im_i (aux_im_c[i]),
            .ctrl_o   (ctrl_c[i+1]),
            .den_o    (den_c[i+1]),
            .rem_re_o (rem_re_c[i+1]),
            .rem_im_o (rem_im_c[i+1]),
            .q_re_o   (q_re_c[i+1]),
            .q_im_o   (q_im_c[i+1]),
            .sr_a_o   (sr_a_c[i+1]),
            .sr_b_o   (sr_b_c[i+1]),
            .rt_a_o   (rt_a_c[i+1]),
            .rt_b_o   (rt_b_c[i+1]),
            .aux_re_o (aux_re_c[i+1]),
            .aux_im_o (aux_im_c[i+1])
        );
    end

    // final select and saturation
    function automatic logic [W:0] clamp_f(input logic signed [SW-1:0] v);
        if (v > MAXV)
        begin
            return {1'b1, MAXV[W-1:0]};
        end
        if (v < MINV)
        begin
            return {1'b1, MINV[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    cau_ctrl_t            cf;
    logic signed [SW-1:0] qs_re, qs_im, fv_re, fv_im;
    logic [W:0]           c_re, c_im;
    logic [W-1:0]         res_re_next, res_im_next;
    logic [1:0]           status_next;

    always_comb
    begin
        cf    = ctrl_c[W];
        qs_re = {{(SW-W){1'b0}}, q_re_c[W]};
        qs_im = {{(SW-W){1'b0}}, q_im_c[W]};
        fv_re = '0;
        fv_im = '0;
        case (cf.op)
            OP_ADD, OP_SUB, OP_MUL:
            begin
                fv_re = aux_re_c[W];
                fv_im = aux_im_c[W];
            end
            OP_DIV:
            begin
                fv_re = cf.ovf_re ? (cf.neg_re ? MINV - 1 : MAXV + 1)
                                  : (cf.neg_re ? -qs_re : qs_re);
                fv_im = cf.ovf_im ? (cf.neg_im ? MINV - 1 : MAXV + 1)
                                  : (cf.neg_im ? -qs_im : qs_im);
                if (cf.dz)
                begin
                    fv_re = '0;
                    fv_im = '0;
                end
            end
            OP_MAG:
            begin
                fv_re = {{(SW-W){1'b0}}, rt_a_c[W]};
                fv_im = {{(SW-W){1'b0}}, rt_b_c[W]};
            end
            default:
            begin
                fv_re = '0;
                fv_im = '0;
            end
        endcase
        c_re        = clamp_f(fv_re);
        c_im        = clamp_f(fv_im);
        res_re_next = c_re[W-1:0];
        res_im_next = c_im[W-1:0];
        if (cf.op == OP_DIV && cf.dz)
        begin
            status_next = ST_DZ;
        end
        else if (c_re[W] || c_im[W])
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    logic         out_valid_reg;
    logic [W-1:0] res_re_reg, res_im_reg;
    logic [1:0]   status_reg;

    assign advance = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= cf.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

    assign operand.ready = advance;
    assign result.valid  = out_valid_reg;
    assign result.res_re = res_re_reg;
    assign result.res_im = res_im_reg;
    assign result.status = status_reg;

endmodule

/* hdl/cau_cell.sv */
// ----------------------------------------------------------------------------
// cau_cell
// one bit step: restoring divide for both parts, square root for both operands
// ----------------------------------------------------------------------------
module cau_cell
    import cau_pkg::*;
#(
    parameter int W  = 16,
    parameter int RW = 58,
    parameter int SW = 34,
    parameter int K  = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  cau_ctrl_t            ctrl_i,
    input  logic [RW-1:0]        den_i,
    input  logic [RW-1:0]        rem_re_i,
    input  logic [RW-1:0]        rem_im_i,
    input  logic [W-1:0]         q_re_i,
    input  logic [W-1:0]         q_im_i,
    input  logic [RW-1:0]        sr_a_i,
    input  logic [RW-1:0]        sr_b_i,
    input  logic [W-1:0]         rt_a_i,
    input  logic [W-1:0]         rt_b_i,
    input  logic signed [SW-1:0] aux_re_i,
    input  logic signed [SW-1:0] aux_im_i,
    output cau_ctrl_t            ctrl_o,
    output logic [RW-1:0]        den_o,
    output logic [RW-1:0]        rem_re_o,
    output logic [RW-1:0]        rem_im_o,
    output logic [W-1:0]         q_re_o,
    output logic [W-1:0]         q_im_o,
    output logic [RW-1:0]        sr_a_o,
    output logic [RW-1:0]        sr_b_o,
    output logic [W-1:0]         rt_a_o,
    output logic [W-1:0]         rt_b_o,
    output logic signed [SW-1:0] aux_re_o,
    output logic signed [SW-1:0] aux_im_o
);

    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << K;

    cau_ctrl_t            ctrl_reg;
    logic [RW-1:0]        den_reg, rem_re_reg, rem_im_reg, sr_a_reg, sr_b_reg;
    logic [W-1:0]         q_re_reg, q_im_reg, rt_a_reg, rt_b_reg;
    logic signed [SW-1:0] aux_re_reg, aux_im_reg;

    logic [RW-1:0] dsh, ta, tb;
    logic [RW-1:0] rem_re_next, rem_im_next, sr_a_next, sr_b_next;
    logic [W-1:0]  q_re_next, q_im_next, rt_a_next, rt_b_next;

    always_comb
    begin
        dsh = den_i << K;
        ta  = ({{(RW-W){1'b0}}, rt_a_i} << (K + 1)) + ({{(RW-1){1'b0}}, 1'b1} << (2 * K));
        tb  = ({{(RW-W){1'b0}}, rt_b_i} << (K + 1)) + ({{(RW-1){1'b0}}, 1'b1} << (2 * K));
        rem_re_next = rem_re_i;
        rem_im_next = rem_im_i;
        q_re_next   = q_re_i;
        q_im_next   = q_im_i;
        sr_a_next   = sr_a_i;
        sr_b_next   = sr_b_i;
        rt_a_next   = rt_a_i;
        rt_b_next   = rt_b_i;
        if (rem_re_i >= dsh)
        begin
            rem_re_next = rem_re_i - dsh;
            q_re_next   = q_re_i | BIT;
        end
        if (rem_im_i >= dsh)
        begin
            rem_im_next = rem_im_i - dsh;
            q_im_next   = q_im_i | BIT;
        end
        if (sr_a_i >= ta)
        begin
            sr_a_next = sr_a_i - ta;
            rt_a_next = rt_a_i | BIT;
        end
        if (sr_b_i >= tb)
        begin
            sr_b_next = sr_b_i - tb;
            rt_b_next = rt_b_i | BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg    <= den_i;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
            sr_a_reg   <= sr_a_next;
            sr_b_reg   <= sr_b_next;
            rt_a_reg   <= rt_a_next;
            rt_b_reg   <= rt_b_next;
            aux_re_reg <= aux_re_i;
            aux_im_reg <= aux_im_i;
        end
    end

    assign ctrl_o   = ctrl_reg;
    assign den_o    = den_reg;
    assign rem_re_o = rem_re_reg;
    assign rem_im_o = rem_im_reg;
    assign q_re_o   = q_re_reg;
    assign q_im_o   = q_im_reg;
    assign sr_a_o   = sr_a_reg;
    assign sr_b_o   = sr_b_reg;
    assign rt_a_o   = rt_a_reg;
    assign rt_b_o   = rt_b_reg;
    assign aux_re_o = aux_re_reg;
    assign aux_im_o = aux_im_reg;

endmodule

/* hdl/cau_checker.sv */
// ----------------------------------------------------------------------------
// cau_checker
// port level checks for the complex arithmetic unit
// ----------------------------------------------------------------------------
module cau_checker
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  op_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [DATA_WIDTH-1:0] res_re,
    input logic [DATA_WIDTH-1:0] res_im,
    input logic [1:0]            status
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_re) && $stable(res_im) && $stable(status))
        else $error("result beat changed while stalled");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !op_ready)
        else $error("operand accepted while result stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status != 2'd3)
        else $error("undefined status code");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_DZ |-> res_re == '0 && res_im == '0)
        else $error("divide by zero result not zero");

endmodule

bind complex_arithmetic_unit cau_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_cau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_ready  (operand.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_re    (result.res_re),
    .res_im    (result.res_im),
    .status    (result.status)
);

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// checks the complex arithmetic unit against its own predictor: a directed
// table of operands first, then random beats, with random gaps on both sides
// and one long hold-off on the result side
// ----------------------------------------------------------------------------
module testbench
    import cau_pkg::*;
;

    localparam int DW = 16;
    localparam int FB = 8;
    localparam int RANDOM_BEATS = 1600;
    localparam int PIPE_DEPTH = DW + 3;

    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
        logic               known;
        logic signed [15:0] res_re;
        logic signed [15:0] res_im;
        logic [1:0]         status;
    } vec_t;

    typedef struct {
        logic signed [15:0] res_re;
        logic signed [15:0] res_im;
        logic [1:0]         status;
    } complex_res_t;

    logic clk;
    logic rst_n;
    logic send_done;
    logic hold_sink;
    logic no_idle;
    int   mismatches = 0;
    int   accepted = 0;

    complex_res_t expected_q[$];

    cau_in_if  #(.DATA_WIDTH(DW)) operand ();
    cau_out_if #(.DATA_WIDTH(DW)) result ();

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand.sink),
        .result  (result.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = ~clk;
    end

    function automatic longint sat_part(input longint x, inout logic sat);
        if (x > 32767)
        begin
            sat = 1'b1;
            return 32767;
        end
        if (x < -32768)
        begin
            sat = 1'b1;
            return -32768;
        end
        return x;
    endfunction

    function automatic longint root_floor(input longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= n)
                r = r + (64'sd1 <<< b);
        end
        return r;
    endfunction

    function automatic complex_res_t complex_compute(input logic [2:0] op,
                                                     input logic signed [15:0] ar,
                                                     input logic signed [15:0] ai,
                                                     input logic signed [15:0] br,
                                                     input logic signed [15:0] bi);
        complex_res_t r;
        longint xr, xi, yr, yi, re, im, den;
        logic   sat;
        logic   dz;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        re = 0;
        im = 0;
        sat = 1'b0;
        dz = 1'b0;
        case (op)
            OP_ADD:
            begin
                re = xr + yr;
                im = xi + yi;
            end
            OP_SUB:
            begin
                re = xr - yr;
                im = xi - yi;
            end
            OP_MUL:
            begin
                re = (xr * yr - xi * yi) / (64'sd1 <<< FB);
                im = (xr * yi + xi * yr) / (64'sd1 <<< FB);
            end
            OP_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    dz = 1'b1;
                else
                begin
                    re = ((xr * yr + xi * yi) * (64'sd1 <<< FB)) / den;
                    im = ((xi * yr - xr * yi) * (64'sd1 <<< FB)) / den;
                end
            end
            OP_MAG:
            begin
                re = root_floor(xr * xr + xi * xi);
                im = root_floor(yr * yr + yi * yi);
            end
            default:
            begin
            end
        endcase
        re = sat_part(re, sat);
        im = sat_part(im, sat);
        r.res_re = re[15:0];
        r.res_im = im[15:0];
        r.status = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
        return r;
    endfunction

    // directed rows: known results typed in, the rest predicted
    vec_t directed[] = '{
        '{OP_ADD, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1, 16'sh0000, 16'sh0000, ST_OK},
        '{OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0001, 1, 16'sh7fff, 16'sh7fff, ST_SAT},
        '{OP_ADD, -16'sh8000, -16'sh8000, -16'sh0001, 16'sh0000, 1, -16'sh8000, -16'sh8000,
          ST_SAT},
        '{OP_SUB, -16'sh8000, 16'sh7fff, 16'sh0001, -16'sh0001, 1, -16'sh8000, 16'sh7fff,
          ST_SAT},
        '{OP_SUB, 16'sh1234, 16'sh0100, 16'sh0234, 16'sh0100, 1, 16'sh1000, 16'sh0000, ST_OK},
        '{OP_MUL, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, 1, 16'sh0100, 16'sh0000, ST_OK},
        '{OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, ST_OK},
        '{OP_MUL, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0, ST_OK},
        '{OP_MUL, -16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001, 0, 0, 0, ST_OK},
        '{OP_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000, 1, 16'sh0000, 16'sh0000, ST_DZ},
        '{OP_DIV, 16'sh7fff, -16'sh8000, 16'sh0000, 16'sh0000, 1, 16'sh0000, 16'sh0000, ST_DZ},
        '{OP_DIV, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, 1, 16'sh0100, 16'sh0000, ST_OK},
        '{OP_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000, 0, 0, 0, ST_OK},
        '{OP_DIV, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0, ST_OK},
        '{OP_DIV, 16'sh0001, -16'sh0001, 16'sh7fff, -16'sh8000, 0, 0, 0, ST_OK},
        '{OP_MAG, 16'sh0300, 16'sh0400, 16'sh0000, 16'sh0000, 1, 16'sh0500, 16'sh0000, ST_OK},
        '{OP_MAG, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh0000, 0, 0, 0, ST_OK},
        '{OP_MAG, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh0000, 0, 0, 0, ST_OK},
        '{3'd5, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, 16'sh0000, 16'sh0000, ST_OK},
        '{3'd6, -16'sh8000, 16'sh0001, 16'sh0000, 16'sh0000, 1, 16'sh0000, 16'sh0000, ST_OK},
        '{3'd7, 16'sh5555, -16'sh5556, 16'sh2aaa, 16'sh0000, 1, 16'sh0000, 16'sh0000, ST_OK}
    };

    task automatic send_beat(input logic [2:0] op, input logic signed [15:0] ar,
                             input logic signed [15:0] ai, input logic signed [15:0] br,
                             input logic signed [15:0] bi, input logic known,
                             input complex_res_t typed);
        complex_res_t exp;
        while (!no_idle && $urandom_range(99) < 22)
        begin
            operand.valid <= 1'b0;
            @(negedge clk);
        end
        operand.valid <= 1'b1;
        operand.op    <= op;
        operand.a_re  <= ar;
        operand.a_im  <= ai;
        operand.b_re  <= br;
        operand.b_im  <= bi;
        @(posedge clk);
        while (!operand.ready)
            @(posedge clk);
        exp = known ? typed : complex_compute(op, ar, ai, br, bi);
        expected_q.push_back(exp);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_part();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'($urandom_range(255) - 128);
            3: return 16'($urandom_range(2047) - 1024);
            default: return 16'($urandom());
        endcase
    endfunction

    initial
    begin
        complex_res_t typed;
        logic [2:0]   op;
        logic signed [15:0] br, bi;
        rst_n = 1'b0;
        send_done = 1'b0;
        no_idle = 1'b0;
        operand.valid = 1'b0;
        operand.op = OP_ADD;
        operand.a_re = '0;
        operand.a_im = '0;
        operand.b_re = '0;
        operand.b_im = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
        begin
            typed.res_re = directed[i].res_re;
            typed.res_im = directed[i].res_im;
            typed.status = directed[i].status;
            send_beat(directed[i].op, directed[i].a_re, directed[i].a_im,
                      directed[i].b_re, directed[i].b_im, directed[i].known, typed);
        end
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            no_idle = (n >= 600 && n < 800);
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            br = rand_part();
            bi = rand_part();
            if (op == OP_DIV && $urandom_range(15) == 0)
            begin
                br = '0;
                bi = '0;
            end
            send_beat(op, rand_part(), rand_part(), br, bi, 1'b0, typed);
        end
        operand.valid <= 1'b0;
        send_done = 1'b1;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        hold_sink = 1'b0;
        @(posedge rst_n);
        while (accepted < 300)
            @(negedge clk);
        hold_sink = 1'b1;
        repeat (200) @(negedge clk);
        hold_sink = 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= !hold_sink && (no_idle || $urandom_range(99) >= 22);
    end

    always @(posedge clk)
    begin
        complex_res_t exp;
        if (operand.valid && operand.ready)
            accepted <= accepted + 1;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat re=%0d im=%0d status=%0d",
                             result.res_re, result.res_im, result.status);
            end
            else
            begin
                exp = expected_q.pop_front();
                if (result.res_re !== exp.res_re || result.res_im !== exp.res_im ||
                    result.status !== exp.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected re=%0d im=%0d status=%0d, ",
                                  "got re=%0d im=%0d status=%0d"},
                                 exp.res_re, exp.res_im, exp.status,
                                 result.res_re, result.res_im, result.status);
                end
            end
        end
    end

    initial
    begin
        wait (send_done === 1'b1);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4 * PIPE_DEPTH) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
hdl/cau_pkg.sv
hdl/cau_in_if.sv
hdl/cau_out_if.sv
hdl/cau_cell.sv
hdl/complex_arithmetic_unit.sv
hdl/cau_checker.sv
test/testbench.sv
